>>> design/cbez_pkg.sv
// ----------------------------------------------------------------------------
// cbez_pkg: shared types and constants for the cubic Bezier easing evaluator
// Field widths, fixed-point constants, register indexes and parameter defaults.
// ----------------------------------------------------------------------------
package cbez_pkg;

  // External field widths
  localparam int TIME_W = 18;
  localparam int PROG_W = 19;
  localparam int CX_W   = 17;
  localparam int CY_W   = 19;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 19;

  // Parameter defaults
  localparam int NEWTON_STEPS_DEF = 8;
  localparam int BISECT_STEPS_DEF = 20;
  localparam int FRAC_BITS_DEF    = 16;

  // Internal fixed point: signed, 32 fraction bits
  localparam int QB = 32;
  typedef logic signed [63:0] qval_t;
  typedef logic [63:0]        qmag_t;

  localparam qval_t Q_ONE   = 64'sd1 <<< QB;
  localparam qval_t TOL     = 64'sd1 <<< (QB - 20);
  localparam qval_t S_LIM   = 64'sd4 <<< QB;
  localparam qmag_t MAG_LIM = 64'h3FFF_FFFF_FFFF_FFFF;

  localparam int OUT_MAX = 262143;
  localparam int OUT_MIN = -262144;

  // Register reset values
  localparam logic [CX_W-1:0] X1_RST = 17'd16384;
  localparam logic [CY_W-1:0] Y1_RST = 19'd6554;
  localparam logic [CX_W-1:0] X2_RST = 17'd16384;
  localparam logic [CY_W-1:0] Y2_RST = 19'd65536;

  // Register indexes
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t REG_X1 = 2'd0;
  localparam cfg_idx_t REG_Y1 = 2'd1;
  localparam cfg_idx_t REG_X2 = 2'd2;
  localparam cfg_idx_t REG_Y2 = 2'd3;

endpackage

>>> design/cbez_ifs.sv
// ----------------------------------------------------------------------------
// cbez channel interfaces
// Valid/ready channels for time requests, progress results and register writes.
// ----------------------------------------------------------------------------
interface cbez_req_if;
  logic                              valid;
  logic                              ready;
  logic signed [cbez_pkg::TIME_W-1:0] time_fraction;
  modport source (output valid, output time_fraction, input ready);
  modport sink   (input valid, input time_fraction, output ready);
endinterface

interface cbez_rsp_if;
  logic                              valid;
  logic                              ready;
  logic signed [cbez_pkg::PROG_W-1:0] eased_progress;
  modport source (output valid, output eased_progress, input ready);
  modport sink   (input valid, input eased_progress, output ready);
endinterface

interface cbez_cfg_if;
  logic                               valid;
  logic                               ready;
  cbez_pkg::cfg_idx_t                 index;
  logic [cbez_pkg::CFG_DATA_W-1:0]    data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> design/cubic_bezier_easing_eval.sv
// ----------------------------------------------------------------------------
// cubic_bezier_easing_eval: eased progress of a unit cubic Bezier curve
// Solves x(s)=t by Newton steps with a bisection fallback, returns y(s).
// ----------------------------------------------------------------------------
//  channel | dir | payload                         | transaction when
//  --------+-----+---------------------------------+-------------------------
//  req     | in  | time_fraction  s18 Q1.16         | req.valid & req.ready
//  rsp     | out | eased_progress s19 Q2.16         | rsp.valid & rsp.ready
//  cfg     | in  | index 2b, data 19b (x1,y1,x2,y2) | cfg.valid & cfg.ready
//
//  Steps: t at or below 0 or at or above 1 skips the solver. Otherwise each
//  Horner step uses the shared 32x32 multiplier (4 partial products), a
//  Newton step evaluates x and x' and runs a 37-step restoring divide, and
//  a bisection step evaluates x.
//  Reset: synchronous rst, registers return to their reset values.
//  req.ready is high only in idle; a result waiting on rsp does not block
//  the next transaction, only the hand-off of the following result.
// ----------------------------------------------------------------------------
module cubic_bezier_easing_eval #(
  parameter int NEWTON_STEPS = cbez_pkg::NEWTON_STEPS_DEF,
  parameter int BISECT_STEPS = cbez_pkg::BISECT_STEPS_DEF,
  parameter int FRAC_BITS    = cbez_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  cbez_req_if.sink    req,
  cbez_rsp_if.source  rsp,
  cbez_cfg_if.sink    cfg
);

  localparam int SH  = cbez_pkg::QB - FRAC_BITS;
  localparam int NW  = (NEWTON_STEPS > 1) ? $clog2(NEWTON_STEPS) : 1;
  localparam int BW  = (BISECT_STEPS > 1) ? $clog2(BISECT_STEPS) : 1;
  localparam logic [NW-1:0] N_LAST = NW'(NEWTON_STEPS - 1);
  localparam logic [BW-1:0] B_LAST = BW'(BISECT_STEPS - 1);
  // 1.0 at the input scale, and its saturated output value
  localparam logic signed [31:0] ONE_IN = 32'sd1 <<< FRAC_BITS;
  localparam int ONE_OUT = (FRAC_BITS <= 17) ? (1 << FRAC_BITS) : cbez_pkg::OUT_MAX;
  localparam cbez_pkg::qmag_t HALF = 64'd1 << (SH - 1);
  localparam logic [5:0] DIV_LAST = 6'd36;
  localparam logic [5:0] DIV_INT_END = 6'd4;

  typedef enum logic [3:0] {
    S_IDLE, S_COEF_X, S_COEF_Y, S_HORNER, S_N_CHK, S_N_DCHK, S_DIV, S_N_UPD,
    S_CLAMP, S_C_CHK, S_B_MID, S_B_CHK, S_ROUND, S_PUSH
  } state_t;

  typedef enum logic [1:0] {K_PX, K_PY, K_PD} hkind_t;

  function automatic cbez_pkg::qmag_t mag(input cbez_pkg::qval_t v);
    mag = v[63] ? cbez_pkg::qmag_t'(-v) : cbez_pkg::qmag_t'(v);
  endfunction

  // configuration registers
  logic [cbez_pkg::CX_W-1:0] x1, x2;
  logic [cbez_pkg::CY_W-1:0] y1, y2;

  state_t state, ret;
  hkind_t hkind;
  logic [1:0] hk;
  logic [2:0] mph;
  cbez_pkg::qval_t hacc, harg, t_q, s, xres, lo, hi;
  cbez_pkg::qval_t ax, bx, cx, ay, by, cy;
  cbez_pkg::qmag_t ma, mb, prod, psum;
  logic mneg;
  logic [NW-1:0] nit;
  logic [BW-1:0] bcnt;
  logic [68:0] rem, dsh;
  logic [35:0] quo;
  logic [5:0]  dcnt;
  logic qneg, qsat, md_zero;
  logic signed [cbez_pkg::PROG_W-1:0] yres, out_data;
  logic out_vld;

  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;
  assign rsp.valid = out_vld;
  assign rsp.eased_progress = out_data;

  // ---- shared multiplier: one 32x32 partial product per cycle ----
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  cbez_pkg::qmag_t term;
  logic [64:0] rnd;
  always_comb begin
    mul_a = (mph == 3'd1 || mph == 3'd2) ? ma[63:32] : ma[31:0];
    mul_b = (mph == 3'd1 || mph == 3'd3) ? mb[63:32] : mb[31:0];
    mul_p = mul_a * mul_b;
    rnd   = {1'b0, prod} + 65'h0_8000_0000;
    case (mph)
      3'd2:    term = {prod[31:0], 32'd0};
      3'd3:    term = prod;
      3'd4:    term = prod;
      3'd5:    term = {31'd0, rnd[64:32]};
      default: term = '0;
    endcase
  end

  // product magnitude clamp, sign, and Horner addend
  cbez_pkg::qmag_t mres;
  cbez_pkg::qval_t mval, addend;
  logic h_last;
  always_comb begin
    mres = (psum > cbez_pkg::MAG_LIM) ? cbez_pkg::MAG_LIM : psum;
    mval = mneg ? -cbez_pkg::qval_t'(mres) : cbez_pkg::qval_t'(mres);
    case (hkind)
      K_PX:    addend = (hk == 2'd0) ? bx : (hk == 2'd1) ? cx : '0;
      K_PY:    addend = (hk == 2'd0) ? by : (hk == 2'd1) ? cy : '0;
      K_PD:    addend = (hk == 2'd0) ? (bx <<< 1) : cx;
      default: addend = '0;
    endcase
    h_last = (hkind == K_PD) ? (hk == 2'd1) : (hk == 2'd2);
  end

  // ---- restoring divider step ----
  logic [68:0] opnd;
  logic [69:0] diff;
  logic ge;
  always_comb begin
    opnd = (dcnt > DIV_INT_END) ? {rem[67:0], 1'b0} : rem;
    diff = {1'b0, opnd} - {1'b0, dsh};
    ge   = ~diff[69];
  end

  // ---- per-state datapath helpers ----
  cbez_pkg::qval_t xd, x1q, x2q, y1q, y2q, qmag_v, qv, s_dif, s_upd, s_clp, mid;
  cbez_pkg::qmag_t ymag, ym;
  logic signed [31:0] t_ext;
  logic x_in_tol, d_small;
  always_comb begin
    t_ext = 32'(req.time_fraction);
    xd    = hacc - t_q;
    x_in_tol = (xd > -cbez_pkg::TOL) && (xd < cbez_pkg::TOL);
    d_small  = (hacc < cbez_pkg::TOL) && (hacc > -cbez_pkg::TOL);
    x1q = cbez_pkg::qval_t'({47'd0, x1}) <<< SH;
    x2q = cbez_pkg::qval_t'({47'd0, x2}) <<< SH;
    y1q = cbez_pkg::qval_t'({{45{y1[18]}}, y1}) <<< SH;
    y2q = cbez_pkg::qval_t'({{45{y2[18]}}, y2}) <<< SH;
    qmag_v = md_zero ? '0 : qsat ? (64'sd16 <<< cbez_pkg::QB) :
             cbez_pkg::qval_t'({28'd0, quo});
    qv    = qneg ? -qmag_v : qmag_v;
    s_dif = s - qv;
    s_upd = (s_dif > cbez_pkg::S_LIM) ? cbez_pkg::S_LIM :
            (s_dif < -cbez_pkg::S_LIM) ? -cbez_pkg::S_LIM : s_dif;
    s_clp = (s < 0) ? '0 : (s > cbez_pkg::Q_ONE) ? cbez_pkg::Q_ONE : s;
    mid   = (lo + hi) >>> 1;
    ymag  = mag(hacc);
    ym    = (ymag + HALF) >> SH;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      ret     <= S_IDLE;
      out_vld <= 1'b0;
      x1 <= cbez_pkg::X1_RST;
      y1 <= cbez_pkg::Y1_RST;
      x2 <= cbez_pkg::X2_RST;
      y2 <= cbez_pkg::Y2_RST;
      mph <= '0;
      hk  <= '0;
      nit <= '0;
      bcnt <= '0;
      dcnt <= '0;
    end else begin
      if (cfg.valid) begin
        case (cfg.index)
          cbez_pkg::REG_X1: x1 <= cfg.data[cbez_pkg::CX_W-1:0];
          cbez_pkg::REG_Y1: y1 <= cfg.data;
          cbez_pkg::REG_X2: x2 <= cfg.data[cbez_pkg::CX_W-1:0];
          cbez_pkg::REG_Y2: y2 <= cfg.data;
          default: ;
        endcase
      end
      // output register: load from S_PUSH when free, else clear on hand-off
      if (state == S_PUSH && (!out_vld || rsp.ready)) begin
        out_vld <= 1'b1;
      end else if (out_vld && rsp.ready) begin
        out_vld <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (req.valid) begin
            if (t_ext <= 0) begin
              yres  <= '0;
              state <= S_PUSH;
            end else if (t_ext >= ONE_IN) begin
              yres  <= cbez_pkg::PROG_W'(ONE_OUT);
              state <= S_PUSH;
            end else begin
              t_q   <= cbez_pkg::qval_t'(t_ext) <<< SH;
              state <= S_COEF_X;
            end
          end
        end
        S_COEF_X: begin
          cx <= (x1q <<< 1) + x1q;
          bx <= (x2q <<< 1) + x2q - (x1q <<< 2) - (x1q <<< 1);
          ax <= cbez_pkg::Q_ONE + (x1q <<< 1) + x1q - (x2q <<< 1) - x2q;
          state <= S_COEF_Y;
        end
        S_COEF_Y: begin
          cy <= (y1q <<< 1) + y1q;
          by <= (y2q <<< 1) + y2q - (y1q <<< 2) - (y1q <<< 1);
          ay <= cbez_pkg::Q_ONE + (y1q <<< 1) + y1q - (y2q <<< 1) - y2q;
          s   <= t_q;
          nit <= '0;
          hacc <= ax; harg <= t_q; hkind <= K_PX; hk <= '0; mph <= '0;
          ret <= S_N_CHK; state <= S_HORNER;
        end
        S_HORNER: begin
          // acc = acc*arg + addend, product rounded half away from zero
          case (mph)
            3'd0: begin
              ma   <= mag(hacc);
              mb   <= mag(harg);
              mneg <= hacc[63] ^ harg[63];
            end
            3'd1: psum <= '0;
            default: psum <= psum + term;
          endcase
          prod <= mul_p;
          if (mph == 3'd6) begin
            hacc <= mval + addend;
            mph  <= '0;
            if (h_last) state <= ret;
            else hk <= hk + 2'd1;
          end else begin
            mph <= mph + 3'd1;
          end
        end
        S_N_CHK: begin
          if (x_in_tol) begin
            state <= S_CLAMP;
          end else begin
            xres <= xd;
            hacc <= (ax <<< 1) + ax; harg <= s; hkind <= K_PD; hk <= '0; mph <= '0;
            ret <= S_N_DCHK; state <= S_HORNER;
          end
        end
        S_N_DCHK: begin
          if (d_small) begin
            state <= S_CLAMP;
          end else begin
            rem     <= {5'd0, mag(xres)};
            dsh     <= {1'b0, mag(hacc), 4'd0};
            md_zero <= (hacc == 0);
            qneg    <= xres[63] ^ hacc[63];
            qsat    <= 1'b0;
            quo     <= '0;
            dcnt    <= '0;
            state   <= S_DIV;
          end
        end
        S_DIV: begin
          // first step tests quotient >= 16, then 4 integer and 32 fraction bits
          if (dcnt == 6'd0 && ge) begin
            qsat  <= 1'b1;
            state <= S_N_UPD;
          end else begin
            rem <= ge ? diff[68:0] : opnd;
            quo <= {quo[34:0], ge};
            if (dcnt < DIV_INT_END) dsh <= dsh >> 1;
            if (dcnt == DIV_LAST) state <= S_N_UPD;
            dcnt <= dcnt + 6'd1;
          end
        end
        S_N_UPD: begin
          s <= s_upd;
          if (nit == N_LAST) begin
            state <= S_CLAMP;
          end else begin
            nit <= nit + NW'(1);
            hacc <= ax; harg <= s_upd; hkind <= K_PX; hk <= '0; mph <= '0;
            ret <= S_N_CHK; state <= S_HORNER;
          end
        end
        S_CLAMP: begin
          s <= s_clp;
          hacc <= ax; harg <= s_clp; hkind <= K_PX; hk <= '0; mph <= '0;
          ret <= S_C_CHK; state <= S_HORNER;
        end
        S_C_CHK: begin
          if (hacc < t_q - cbez_pkg::TOL || hacc > t_q + cbez_pkg::TOL) begin
            lo    <= '0;
            hi    <= cbez_pkg::Q_ONE;
            bcnt  <= '0;
            state <= S_B_MID;
          end else begin
            hacc <= ay; harg <= s; hkind <= K_PY; hk <= '0; mph <= '0;
            ret <= S_ROUND; state <= S_HORNER;
          end
        end
        S_B_MID: begin
          s <= mid;
          hacc <= ax; harg <= mid; hkind <= K_PX; hk <= '0; mph <= '0;
          ret <= S_B_CHK; state <= S_HORNER;
        end
        S_B_CHK: begin
          if (hacc < t_q) lo <= s;
          else hi <= s;
          if ((hacc > t_q - cbez_pkg::TOL && hacc < t_q + cbez_pkg::TOL) ||
              bcnt == B_LAST) begin
            hacc <= ay; harg <= s; hkind <= K_PY; hk <= '0; mph <= '0;
            ret <= S_ROUND; state <= S_HORNER;
          end else begin
            bcnt  <= bcnt + BW'(1);
            state <= S_B_MID;
          end
        end
        S_ROUND: begin
          // round to output scale, then saturate
          if (!hacc[63]) begin
            yres <= (ym > 64'(cbez_pkg::OUT_MAX)) ? cbez_pkg::PROG_W'(cbez_pkg::OUT_MAX)
                                                  : cbez_pkg::PROG_W'(ym);
          end else begin
            yres <= (ym > 64'(-cbez_pkg::OUT_MIN)) ? cbez_pkg::PROG_W'(cbez_pkg::OUT_MIN)
                                                   : -cbez_pkg::PROG_W'(ym);
          end
          state <= S_PUSH;
        end
        S_PUSH: begin
          if (!out_vld || rsp.ready) begin
            out_data <= yres;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> state != S_IDLE)
    else $error("accepted transaction did not start work");

  a_newton_s_bounded: assert property (@(posedge clk) disable iff (rst)
    (state == S_N_CHK) |-> (s >= -cbez_pkg::S_LIM && s <= cbez_pkg::S_LIM))
    else $error("Newton iterate out of range");

  a_bisect_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_B_MID) |-> (lo < hi && lo >= 0 && hi <= cbez_pkg::Q_ONE))
    else $error("bisection bracket broken");

  a_div_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> dcnt <= DIV_LAST)
    else $error("divider ran past its last step");
`endif

endmodule
